// ----- rtl/power_iteration_eigen_2x2_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef POWER_ITERATION_EIGEN_2X2_CORE_MACROS_SVH
`define POWER_ITERATION_EIGEN_2X2_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIE_ASSERT_IMPL(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("pie property failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIE_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("pie property failed");

`endif

// ----- rtl/pie_pkg.sv -----
`default_nettype none
package pie_pkg;

	localparam int DATA_W         = 32;
	localparam int COUNT_W        = 8;
	localparam int CFG_IDX_W      = 3;
	localparam int STATUS_W       = 2;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int MAX_ITERATIONS = 255;
	localparam int DIVISOR_W      = 64;
	localparam int QUO_W          = 33;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_A00   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_A01   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_A10   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_A11   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd2;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_A_NX,
		MUL_B_Y,
		MUL_C_X,
		MUL_D_Y,
		MUL_A_ONE,
		MUL_B_X1,
		MUL_C_ONE,
		MUL_D_X1,
		MUL_Y1_X1,
		MUL_X1_X1
	} mul_op_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ROW0,
		ACC_ROW1,
		ACC_Y1
	} acc_op_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_START_X1,
		DIV_START_EIG,
		DIV_STEP
	} div_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ITER0,
		S_ITER1,
		S_ITER2,
		S_ITER3,
		S_ITER_END,
		S_CHECK,
		S_DIV1,
		S_X1,
		S_FIN0,
		S_FIN1,
		S_FIN2,
		S_FIN3,
		S_FIN4,
		S_FIN5,
		S_FIN6,
		S_FIN7,
		S_DIV2_START,
		S_DIV2,
		S_EIG,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    load;
		logic    load_zero;
		mul_op_t mul_op;
		acc_op_t acc_op;
		div_op_t div_op;
		logic    x1_load;
		logic    num_load;
		logic    den_load;
		logic    eig_load;
		logic    out_load;
		logic    out_zero;
	} cmd_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count_lim;
		logic               x_zero;
	} sts_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              sat;
	} sat_res_t;

	// Clamp a wide signed value into 32 bits and flag the clamp
	function automatic sat_res_t sat32(input logic signed [71:0] v);
		sat_res_t r;
		if (v > 72'sd2147483647) begin
			r.value = 32'h7FFF_FFFF;
			r.sat   = 1'b1;
		end else if (v < -72'sd2147483648) begin
			r.value = 32'h8000_0000;
			r.sat   = 1'b1;
		end else begin
			r.value = v[31:0];
			r.sat   = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/pie_div.sv -----
`default_nettype none
module pie_div #(
	parameter int DVD_W = pie_pkg::DIVISOR_W + pie_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          start,
	input  wire logic                          step,
	input  wire logic [DVD_W-1:0]              dividend,
	input  wire logic [pie_pkg::DIVISOR_W-1:0] divisor,
	output logic      [pie_pkg::QUO_W-1:0]     quo,
	output logic                               ovf
);
	import pie_pkg::*;

	logic [DVD_W-1:0]     dvd_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 ovf_q;

	logic [DIVISOR_W:0] shifted;
	logic [DIVISOR_W:0] diff;
	logic               ge;

	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	// Restoring division, one dividend bit per step, MSB first
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (step) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
			// drop high quotient bits but remember that one was set
			ovf_q <= ovf_q | quo_q[QUO_W-1];
		end
	end

	assign quo = quo_q;
	assign ovf = ovf_q;

endmodule
`default_nettype wire

// ----- rtl/pie_ctrl.sv -----
`default_nettype none
module pie_ctrl #(
	parameter int FRAC_BITS = pie_pkg::FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire pie_pkg::sts_t sts,
	output pie_pkg::cmd_t      cmd
);
	import pie_pkg::*;

	localparam int DIV_W  = DIVISOR_W + FRAC_BITS;
	localparam int DCNT_W = $clog2(DIV_W);

	state_t             state_q, state_d;
	logic [COUNT_W-1:0] iter_q, iter_d;
	logic               first_q, first_d;
	logic               zero_q, zero_d;
	logic [DCNT_W-1:0]  dcnt_q, dcnt_d;
	logic               out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iter_q      <= '0;
			first_q     <= 1'b0;
			zero_q      <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			iter_q      <= iter_d;
			first_q     <= first_d;
			zero_q      <= zero_d;
			dcnt_q      <= dcnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		iter_d        = iter_q;
		first_d       = first_q;
		zero_d        = zero_q;
		dcnt_d        = dcnt_q;
		out_valid_d   = out_valid_q && !out_ready;
		cmd           = '0;
		cmd.mul_op    = MUL_NONE;
		cmd.acc_op    = ACC_NONE;
		cmd.div_op    = DIV_IDLE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load      = 1'b1;
					cmd.load_zero = (sts.count_lim == '0);
					iter_d        = sts.count_lim;
					first_d       = 1'b1;
					zero_d        = 1'b0;
					state_d       = (sts.count_lim == '0) ? S_CHECK : S_ITER0;
				end
			end
			S_ITER0: begin
				cmd.mul_op = MUL_A_NX;
				// retire the previous iteration's second row
				if (!first_q)
					cmd.acc_op = ACC_ROW1;
				first_d = 1'b0;
				state_d = S_ITER1;
			end
			S_ITER1: begin
				cmd.mul_op = MUL_B_Y;
				cmd.acc_op = ACC_LOAD;
				state_d    = S_ITER2;
			end
			S_ITER2: begin
				cmd.mul_op = MUL_C_X;
				cmd.acc_op = ACC_ROW0;
				state_d    = S_ITER3;
			end
			S_ITER3: begin
				cmd.mul_op = MUL_D_Y;
				cmd.acc_op = ACC_LOAD;
				iter_d     = iter_q - COUNT_W'(1);
				state_d    = (iter_q == COUNT_W'(1)) ? S_ITER_END : S_ITER0;
			end
			S_ITER_END: begin
				cmd.acc_op = ACC_ROW1;
				state_d    = S_CHECK;
			end
			S_CHECK: begin
				if (sts.x_zero) begin
					zero_d  = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.div_op = DIV_START_X1;
					dcnt_d     = DCNT_W'(DIV_W - 1);
					state_d    = S_DIV1;
				end
			end
			S_DIV1: begin
				cmd.div_op = DIV_STEP;
				dcnt_d     = dcnt_q - DCNT_W'(1);
				if (dcnt_q == '0)
					state_d = S_X1;
			end
			S_X1: begin
				cmd.x1_load = 1'b1;
				state_d     = S_FIN0;
			end
			S_FIN0: begin
				cmd.mul_op = MUL_A_ONE;
				state_d    = S_FIN1;
			end
			S_FIN1: begin
				cmd.mul_op = MUL_B_X1;
				cmd.acc_op = ACC_LOAD;
				state_d    = S_FIN2;
			end
			S_FIN2: begin
				cmd.mul_op = MUL_C_ONE;
				cmd.acc_op = ACC_ROW0;
				state_d    = S_FIN3;
			end
			S_FIN3: begin
				cmd.mul_op = MUL_D_X1;
				cmd.acc_op = ACC_LOAD;
				state_d    = S_FIN4;
			end
			S_FIN4: begin
				cmd.acc_op = ACC_Y1;
				state_d    = S_FIN5;
			end
			S_FIN5: begin
				cmd.mul_op = MUL_Y1_X1;
				state_d    = S_FIN6;
			end
			S_FIN6: begin
				cmd.mul_op   = MUL_X1_X1;
				cmd.num_load = 1'b1;
				state_d      = S_FIN7;
			end
			S_FIN7: begin
				cmd.den_load = 1'b1;
				state_d      = S_DIV2_START;
			end
			S_DIV2_START: begin
				cmd.div_op = DIV_START_EIG;
				dcnt_d     = DCNT_W'(DIV_W - 1);
				state_d    = S_DIV2;
			end
			S_DIV2: begin
				cmd.div_op = DIV_STEP;
				dcnt_d     = dcnt_q - DCNT_W'(1);
				if (dcnt_q == '0)
					state_d = S_EIG;
			end
			S_EIG: begin
				cmd.eig_load = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free or being emptied
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					cmd.out_zero = zero_q;
					out_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/pie_datapath.sv -----
`default_nettype none
module pie_datapath #(
	parameter int FRAC_BITS = pie_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	input  wire logic [pie_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pie_pkg::DATA_W-1:0]          cfg_data,
	input  wire logic signed [pie_pkg::DATA_W-1:0]   start_first,
	input  wire logic signed [pie_pkg::DATA_W-1:0]   start_second,
	input  wire pie_pkg::cmd_t                       cmd,
	output pie_pkg::sts_t                            sts,
	output logic signed [pie_pkg::DATA_W-1:0]        eigen_estimate,
	output logic signed [pie_pkg::DATA_W-1:0]        last_first,
	output logic signed [pie_pkg::DATA_W-1:0]        last_second,
	output logic        [pie_pkg::STATUS_W-1:0]      status
);
	import pie_pkg::*;

	localparam int DIV_W = DIVISOR_W + FRAC_BITS;
	localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRAC_BITS);

	// configuration
	logic signed [DATA_W-1:0] a00_q, a01_q, a10_q, a11_q;
	logic [COUNT_W-1:0]       count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a00_q   <= '0;
			a01_q   <= '0;
			a10_q   <= '0;
			a11_q   <= '0;
			count_q <= COUNT_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_A00:   a00_q   <= cfg_data;
				CFG_A01:   a01_q   <= cfg_data;
				CFG_A10:   a10_q   <= cfg_data;
				CFG_A11:   a11_q   <= cfg_data;
				CFG_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// working registers
	logic signed [DATA_W-1:0]  x_q, y_q, nx_q, x1_q, y1_q, eig_q;
	logic signed [63:0]        acc_q, prod_q, num_q;
	logic [DIVISOR_W-1:0]      den_q;
	logic                      sat_q, div_neg_q;
	logic signed [DATA_W-1:0]  out_eig_q, out_first_q, out_second_q;
	logic [STATUS_W-1:0]       out_status_q;

	// shared multiplier operands
	logic signed [DATA_W-1:0] op_a, op_b;
	logic signed [63:0]       mul_p;

	always_comb begin
		case (cmd.mul_op)
			MUL_A_NX:  begin op_a = a00_q; op_b = nx_q; end
			MUL_B_Y:   begin op_a = a01_q; op_b = y_q;  end
			MUL_C_X:   begin op_a = a10_q; op_b = x_q;  end
			MUL_D_Y:   begin op_a = a11_q; op_b = y_q;  end
			MUL_A_ONE: begin op_a = a00_q; op_b = ONE;  end
			MUL_B_X1:  begin op_a = a01_q; op_b = x1_q; end
			MUL_C_ONE: begin op_a = a10_q; op_b = ONE;  end
			MUL_D_X1:  begin op_a = a11_q; op_b = x1_q; end
			MUL_Y1_X1: begin op_a = y1_q;  op_b = x1_q; end
			MUL_X1_X1: begin op_a = x1_q;  op_b = x1_q; end
			default:   begin op_a = '0;    op_b = '0;   end
		endcase
	end

	assign mul_p = op_a * op_b;

	// row result: exact sum of two products, floor shift, clamp
	logic signed [64:0] sum_w, shifted_w;
	sat_res_t           row_r;

	assign sum_w     = 65'(acc_q) + 65'(prod_q);
	assign shifted_w = sum_w >>> FRAC_BITS;
	assign row_r     = sat32(72'(shifted_w));

	logic signed [63:0]   num_w;
	logic [DIVISOR_W-1:0] den_w;

	assign num_w = 64'(nx_q) + (prod_q >>> FRAC_BITS);
	assign den_w = DIVISOR_W'(ONE) + DIVISOR_W'(prod_q >>> FRAC_BITS);

	// divider operands
	logic [DATA_W-1:0]    mag_x, mag_y;
	logic [63:0]          mag_num;
	logic [DIV_W-1:0]     dvd_in;
	logic [DIVISOR_W-1:0] dsr_in;
	logic                 div_start, div_step;
	logic [QUO_W-1:0]     div_quo;
	logic                 div_ovf;

	assign mag_x   = x_q[DATA_W-1] ? -x_q : x_q;
	assign mag_y   = y_q[DATA_W-1] ? -y_q : y_q;
	assign mag_num = num_q[63] ? -num_q : num_q;

	assign div_start = (cmd.div_op == DIV_START_X1) || (cmd.div_op == DIV_START_EIG);
	assign div_step  = (cmd.div_op == DIV_STEP);

	always_comb begin
		if (cmd.div_op == DIV_START_EIG) begin
			dvd_in = DIV_W'(mag_num) << FRAC_BITS;
			dsr_in = den_q;
		end else begin
			dvd_in = DIV_W'(mag_y) << FRAC_BITS;
			dsr_in = DIVISOR_W'(mag_x);
		end
	end

	pie_div #(
		.DVD_W(DIV_W)
	) u_div (
		.clk      (clk),
		.start    (div_start),
		.step     (div_step),
		.dividend (dvd_in),
		.divisor  (dsr_in),
		.quo      (div_quo),
		.ovf      (div_ovf)
	);

	// apply sign to the quotient magnitude and clamp
	sat_res_t quo_r;
	logic     q_big;

	assign q_big = div_ovf || div_quo[QUO_W-1];

	always_comb begin
		if (div_neg_q) begin
			if (q_big || (div_quo[DATA_W-1:0] > 32'h8000_0000)) begin
				quo_r.value = 32'h8000_0000;
				quo_r.sat   = 1'b1;
			end else begin
				quo_r.value = 32'd0 - div_quo[DATA_W-1:0];
				quo_r.sat   = 1'b0;
			end
		end else begin
			if (q_big || div_quo[DATA_W-1]) begin
				quo_r.value = 32'h7FFF_FFFF;
				quo_r.sat   = 1'b1;
			end else begin
				quo_r.value = div_quo[DATA_W-1:0];
				quo_r.sat   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (cmd.load) begin
			x_q   <= cmd.load_zero ? '0 : start_first;
			y_q   <= cmd.load_zero ? '0 : start_second;
			nx_q  <= start_first;
			sat_q <= 1'b0;
		end
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= prod_q;
			ACC_ROW0: begin
				nx_q  <= row_r.value;
				sat_q <= sat_q | row_r.sat;
			end
			ACC_ROW1: begin
				x_q   <= nx_q;
				y_q   <= row_r.value;
				sat_q <= sat_q | row_r.sat;
			end
			ACC_Y1: begin
				y1_q  <= row_r.value;
				sat_q <= sat_q | row_r.sat;
			end
			default: ;
		endcase
		if (div_start) begin
			div_neg_q <= (cmd.div_op == DIV_START_EIG) ? num_q[63]
			                                           : (x_q[DATA_W-1] ^ y_q[DATA_W-1]);
		end
		if (cmd.x1_load) begin
			x1_q  <= quo_r.value;
			sat_q <= sat_q | quo_r.sat;
		end
		if (cmd.num_load)
			num_q <= num_w;
		if (cmd.den_load)
			den_q <= den_w;
		if (cmd.eig_load) begin
			eig_q <= quo_r.value;
			sat_q <= sat_q | quo_r.sat;
		end
		if (cmd.out_load) begin
			out_eig_q    <= cmd.out_zero ? '0 : eig_q;
			out_first_q  <= x_q;
			out_second_q <= y_q;
			out_status_q <= cmd.out_zero ? STATUS_ZERO : (sat_q ? STATUS_SAT : STATUS_OK);
		end
	end

	always_comb begin
		sts.x_zero    = (x_q == '0);
		sts.count_lim = ({8'd0, count_q} > 16'(MAX_ITERATIONS)) ? COUNT_W'(MAX_ITERATIONS)
		                                                       : count_q;
	end

	assign eigen_estimate = out_eig_q;
	assign last_first     = out_first_q;
	assign last_second    = out_second_q;
	assign status         = out_status_q;

endmodule
`default_nettype wire

// ----- rtl/power_iteration_eigen_2x2_core.sv -----
`default_nettype none
// Dominant eigenvalue of a 2x2 Q(32-FRAC_BITS).FRAC_BITS matrix by power iteration, one start
// vector at a time on a single shared 32x32 multiplier and a bit-serial divider. Each item
// runs n iterations, n being the CFG_COUNT setting limited to MAX_ITERATIONS: four multiplier
// passes per iteration, then two restoring divisions of 64 + FRAC_BITS steps each. If the
// first component ends at zero the divisions are skipped. in_ready returns as the result is
// loaded into the output register, so items are taken one at a time. in_ready is high only
// between items; a finished result sits in the output register while the next item is
// already taken. Configuration writes are always ready and take effect at once; write them
// only while no item is in flight.
module power_iteration_eigen_2x2_core #(
	parameter int FRAC_BITS = pie_pkg::FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [pie_pkg::DATA_W-1:0] start_first,
	input  wire logic signed [pie_pkg::DATA_W-1:0] start_second,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [pie_pkg::DATA_W-1:0]      eigen_estimate,
	output logic signed [pie_pkg::DATA_W-1:0]      last_first,
	output logic signed [pie_pkg::DATA_W-1:0]      last_second,
	output logic        [pie_pkg::STATUS_W-1:0]    status,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [pie_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pie_pkg::DATA_W-1:0]        cfg_data
);
	import pie_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	pie_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pie_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start_first    (start_first),
		.start_second   (start_second),
		.cmd            (cmd),
		.sts            (sts),
		.eigen_estimate (eigen_estimate),
		.last_first     (last_first),
		.last_second    (last_second),
		.status         (status)
	);

endmodule
`default_nettype wire

// ----- rtl/pie_checker.sv -----
`default_nettype none
`include "power_iteration_eigen_2x2_core_macros.svh"
module pie_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic signed [pie_pkg::DATA_W-1:0] eigen_estimate,
	input wire logic signed [pie_pkg::DATA_W-1:0] last_first,
	input wire logic signed [pie_pkg::DATA_W-1:0] last_second,
	input wire logic        [pie_pkg::STATUS_W-1:0] status
);
	import pie_pkg::*;

	// a stalled result holds
	`PIE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(eigen_estimate) && $stable(last_first) && $stable(last_second) && $stable(status))

	// one item in flight: no second transfer straight after the first
	`PIE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	`PIE_ASSERT_IMPL(a_zero_eig, clk, arst_n, out_valid && (status == STATUS_ZERO), eigen_estimate == '0)

	`PIE_ASSERT_IMPL(a_zero_first, clk, arst_n, out_valid && (status == STATUS_ZERO), last_first == '0)

endmodule

bind power_iteration_eigen_2x2_core pie_checker u_checker (.*);
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import pie_pkg::*;

	localparam int FRAC_Q = FRAC_BITS_DEF;
	localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_Q;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam int RANDOM_ITEMS = 470;

	typedef enum {
		MAT_MODERATE,
		MAT_FRACTION,
		MAT_WIDE,
		MAT_SYMMETRIC,
		MAT_INTEGER
	} mat_kind_e;

	typedef struct {
		logic [31:0]         eig;
		logic [31:0]         first;
		logic [31:0]         second;
		logic [STATUS_W-1:0] stat;
	} eigen_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [31:0] start_first;
	logic signed [31:0] start_second;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] eigen_estimate;
	logic signed [31:0] last_first;
	logic signed [31:0] last_second;
	logic [STATUS_W-1:0] status;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	// Shadow of the configuration as the predictor sees it
	logic signed [31:0] mat_shadow [4];
	int iter_shadow;

	eigen_result_t expected_results [$];
	eigen_result_t rx_want;

	int error_count;
	int results_checked;
	int vectors_sent;
	int settings_written;
	int longest_stall;
	int hold_request;
	int rx_stall_left;
	bit idle_en;

	power_iteration_eigen_2x2_core #(
		.FRAC_BITS(FRAC_Q)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_first   (start_first),
		.start_second  (start_second),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.eigen_estimate(eigen_estimate),
		.last_first    (last_first),
		.last_second   (last_second),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic signed [31:0] clamp_q(input logic signed [79:0] v,
		inout bit clipped);
		if (v > 80'sd2147483647) begin
			clipped = 1'b1;
			return Q_MAX;
		end
		if (v < -80'sd2147483648) begin
			clipped = 1'b1;
			return Q_MIN;
		end
		return v[31:0];
	endfunction

	// One matrix row times a vector: exact sum, floor shift, then clamp
	function automatic logic signed [31:0] row_mac(input logic signed [31:0] a, b, x, y,
		inout bit clipped);
		logic signed [79:0] ea, eb, ex, ey, acc;
		ea = a;
		eb = b;
		ex = x;
		ey = y;
		acc = (ea * ex + eb * ey) >>> FRAC_Q;
		return clamp_q(acc, clipped);
	endfunction

	function automatic eigen_result_t predict_eigen(input logic signed [31:0] sf, ss);
		eigen_result_t res;
		bit clipped;
		int k, rounds;
		logic signed [31:0] v0, v1, r0, r1, x1, y0, y1;
		logic signed [79:0] wa, wb, num, den, quo;
		logic [95:0] mag, den_u, quo_u;
		clipped = 1'b0;
		v0 = sf;
		v1 = ss;
		r0 = '0;
		r1 = '0;
		rounds = (iter_shadow > MAX_ITERATIONS) ? MAX_ITERATIONS : iter_shadow;
		for (k = 0; k < rounds; k++) begin
			r0 = row_mac(mat_shadow[0], mat_shadow[1], v0, v1, clipped);
			r1 = row_mac(mat_shadow[2], mat_shadow[3], v0, v1, clipped);
			v0 = r0;
			v1 = r1;
		end
		res.first = r0;
		res.second = r1;
		if (r0 == 0) begin
			// zero first component wins over any clamp seen on the way
			res.eig = '0;
			res.stat = STATUS_ZERO;
		end else begin
			wa = r1;
			wa = wa <<< FRAC_Q;
			wb = r0;
			x1 = clamp_q(wa / wb, clipped);
			y0 = row_mac(mat_shadow[0], mat_shadow[1], ONE_Q, x1, clipped);
			y1 = row_mac(mat_shadow[2], mat_shadow[3], ONE_Q, x1, clipped);
			wa = y1;
			wb = x1;
			num = (wa * wb) >>> FRAC_Q;
			wa = y0;
			num = num + wa;
			den = ((wb * wb) >>> FRAC_Q) + ONE_Q;
			if (num < 0)
				mag = -num;
			else
				mag = num;
			den_u = den;
			quo_u = (mag << FRAC_Q) / den_u;
			// anything this large clamps regardless of its low bits
			if (quo_u > (96'd1 << 33))
				quo_u = 96'd1 << 33;
			quo = quo_u[79:0];
			if (num < 0)
				quo = -quo;
			res.eig = clamp_q(quo, clipped);
			res.stat = clipped ? STATUS_SAT : STATUS_OK;
		end
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 150);
	endfunction

	function automatic logic signed [31:0] span_q(input int unsigned lim);
		int v;
		v = int'($urandom_range(0, 2 * lim)) - int'(lim);
		return v;
	endfunction

	function automatic logic signed [31:0] pick_component();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return span_q(4 * ONE_Q);
			6: return $urandom();
			7: return '0;
			8: begin
				case ($urandom_range(0, 3))
					0: return Q_MIN;
					1: return Q_MAX;
					2: return ONE_Q;
					default: return -ONE_Q;
				endcase
			end
			default: return span_q(256);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_element(input mat_kind_e kind);
		case (kind)
			MAT_FRACTION: return span_q(ONE_Q - 1);
			MAT_WIDE: return $urandom();
			MAT_INTEGER: return (int'($urandom_range(0, 8)) - 4) * ONE_Q;
			default: return span_q(2 * ONE_Q);
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return COUNT_W'(MAX_ITERATIONS);
		if (r < 5)
			return COUNT_W'($urandom_range(13, 64));
		return COUNT_W'($urandom_range(1, 12));
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
				$signed(want), $signed(got));
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, eigen_estimate %0d status %0d", $time,
					eigen_estimate, status);
				error_count++;
			end else begin
				rx_want = expected_results.pop_front();
				check_field("eigen_estimate", rx_want.eig, eigen_estimate);
				check_field("last_first", rx_want.first, last_first);
				check_field("last_second", rx_want.second, last_second);
				check_field("status", 32'(rx_want.stat), 32'(status));
				results_checked++;
			end
		end
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		rx_stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				rx_stall_left = hold_request;
				hold_request = 0;
			end
			if (rx_stall_left > 0) begin
				out_ready <= 1'b0;
				rx_stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (idle_en && $urandom_range(0, 3) == 0)
					rx_stall_left = pick_gap();
			end
			if (rx_stall_left > longest_stall)
				longest_stall = rx_stall_left;
		end
	end

	// Enter and leave at a falling edge; valid stays high after the transfer
	task automatic send_vector(input logic signed [31:0] first_c, second_c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		start_first <= first_c;
		start_second <= second_c;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(predict_eigen(first_c, second_c));
		vectors_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_A00: mat_shadow[0] = value;
			CFG_A01: mat_shadow[1] = value;
			CFG_A10: mat_shadow[2] = value;
			CFG_A11: mat_shadow[3] = value;
			CFG_COUNT: iter_shadow = value[COUNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure_matrix(input logic signed [31:0] a00, a01, a10, a11,
		input logic [COUNT_W-1:0] count);
		wait_drained();
		write_reg(CFG_A00, a00);
		write_reg(CFG_A01, a01);
		write_reg(CFG_A10, a10);
		write_reg(CFG_A11, a11);
		write_reg(CFG_COUNT, 32'(count));
		settings_written++;
	endtask

	// Zero matrix and a count of one out of reset: first component is always zero
	task automatic test_reset_state();
		send_vector(ONE_Q, ONE_Q);
		send_vector(Q_MIN, Q_MAX);
	endtask

	task automatic test_special_cases();
		// no iterations: last iterate is (0, 0)
		configure_matrix(2 * ONE_Q, ONE_Q, ONE_Q, 2 * ONE_Q, 0);
		send_vector(ONE_Q, '0);
		send_vector(Q_MAX, Q_MIN);

		configure_matrix(2 * ONE_Q, ONE_Q, ONE_Q, 2 * ONE_Q, 3);
		send_vector(ONE_Q, '0);
		send_vector(-ONE_Q, ONE_Q + ONE_Q / 2);

		// negative dominant eigenvalue
		configure_matrix(-3 * ONE_Q, '0, '0, ONE_Q, 4);
		send_vector(ONE_Q, ONE_Q);

		configure_matrix(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1);
		send_vector(Q_MIN, Q_MAX);
		send_vector(Q_MAX, Q_MAX);
		send_vector(Q_MIN, Q_MIN);

		configure_matrix(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 2);
		send_vector(Q_MAX, Q_MIN);

		// second row clamps but the zero first component takes precedence
		configure_matrix('0, '0, Q_MAX, Q_MAX, 1);
		send_vector(Q_MAX, Q_MAX);

		// tiny first component drives the scaled second component into the clamp
		configure_matrix(32'sd1, '0, '0, Q_MAX, 1);
		send_vector(ONE_Q, ONE_Q);

		// fractional elements with negative vectors exercise floor rounding
		configure_matrix(ONE_Q / 3, -ONE_Q / 7, ONE_Q / 5, -ONE_Q / 2, 5);
		send_vector(-32'sd12345, 32'sd67890);
		send_vector(-32'sd1, -32'sd1);

		// full iteration count on a permutation matrix stays bounded
		configure_matrix('0, ONE_Q, ONE_Q, '0, COUNT_W'(MAX_ITERATIONS));
		send_vector(3 * ONE_Q, -ONE_Q);
	endtask

	// Writes to indexes past the last register must leave the setting intact
	task automatic test_unknown_register();
		int spare;
		configure_matrix(2 * ONE_Q, '0, '0, ONE_Q, 2);
		for (spare = int'(CFG_COUNT) + 1; spare < (1 << CFG_IDX_W); spare++) begin
			write_reg(CFG_IDX_W'(spare), (spare % 2) ? 32'hFFFF_FFFF : 32'h0);
		end
		send_vector(ONE_Q, ONE_Q);
		send_vector(-ONE_Q / 2, 3 * ONE_Q);
	endtask

	// Hold the result side for a long stretch while items keep coming
	task automatic test_output_stall();
		int k;
		configure_matrix(ONE_Q + ONE_Q / 2, ONE_Q / 4, -ONE_Q / 2, ONE_Q, 3);
		idle_en = 1'b0;
		hold_request = 3000;
		for (k = 0; k < 8; k++)
			send_vector(span_q(4 * ONE_Q), span_q(4 * ONE_Q));
		wait_drained();
		idle_en = 1'b1;
	endtask

	task automatic test_random_phases();
		int random_items;
		int phase_len;
		mat_kind_e kind;
		logic signed [31:0] m00, m01, m10, m11;
		logic [COUNT_W-1:0] count;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			kind = mat_kind_e'($urandom_range(0, 4));
			m00 = pick_element(kind);
			m01 = pick_element(kind);
			m10 = (kind == MAT_SYMMETRIC) ? m01 : pick_element(kind);
			m11 = pick_element(kind);
			count = pick_count();
			configure_matrix(m00, m01, m10, m11, count);
			idle_en = ($urandom_range(0, 3) != 0);
			// keep long iteration counts to a handful of items
			phase_len = (count > 64) ? 3 : $urandom_range(10, 24);
			repeat (phase_len)
				send_vector(pick_component(), pick_component());
			random_items += phase_len;
			wait_drained();
		end
		idle_en = 1'b1;
	endtask

	initial begin
		#8_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_first = '0;
		start_second = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_en = 1'b1;
		hold_request = 0;
		error_count = 0;
		results_checked = 0;
		vectors_sent = 0;
		settings_written = 0;
		longest_stall = 0;
		mat_shadow = '{default: '0};
		iter_shadow = 1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_special_cases();
		test_unknown_register();
		test_output_stall();
		test_random_phases();

		wait_drained();
		// give any stray result time to show up
		repeat (1300) @(posedge clk);

		$display("Checked %0d results from %0d start vectors over %0d matrix settings",
			results_checked, vectors_sent, settings_written);
		$display("Iteration counts 0 to 255 covered, result side held off up to %0d cycles",
			longest_stall);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
